/* design/pba_pkg.sv */
// shared types and codes of the page bitmap allocator
package pba_pkg;

    // command codes
    localparam logic [2:0] CMD_USABLE  = 3'd0;
    localparam logic [2:0] CMD_EXTENT  = 3'd1;
    localparam logic [2:0] CMD_RESERVE = 3'd2;
    localparam logic [2:0] CMD_FINAL   = 3'd3;
    localparam logic [2:0] CMD_ALLOC   = 3'd4;
    localparam logic [2:0] CMD_FREE    = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_OOM    = 2'd2;
    localparam logic [1:0] ST_NOUSE  = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] range_base;
        logic [63:0] range_length;
        logic [31:0] free_address;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] page_address;
        logic [16:0] total_count;
        logic [16:0] free_count;
        logic [16:0] reserved_count;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic clr;
        logic load;
        logic calc1;
        logic calc2;
        logic rd;
        logic wr;
        logic done;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic walk;
        logic last;
        logic clr_last;
    } t_sts;

endpackage

/* design/pba_ctrl.sv */
// controller state machine of the page bitmap allocator
module pba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  pba_pkg::t_sts i_sts,
    output pba_pkg::t_ctl o_ctl
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_CALC1 = 7'b0000100,
        S_CALC2 = 7'b0001000,
        S_READ  = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   w_load_out;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_load_out  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // commands to the datapath
    always_comb begin
        o_ctl       = '0;
        o_ctl.clr   = (r_state == S_CLEAR);
        o_ctl.load  = (r_state == S_IDLE) && i_in_valid;
        o_ctl.calc1 = (r_state == S_CALC1);
        o_ctl.calc2 = (r_state == S_CALC2);
        o_ctl.rd    = (r_state == S_READ);
        o_ctl.wr    = (r_state == S_WRITE);
        o_ctl.done  = w_load_out;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_CALC1;
            S_CALC1: n_state = S_CALC2;
            S_CALC2: n_state = i_sts.walk ? S_READ : S_DONE;
            S_READ:  n_state = S_WRITE;
            S_WRITE: n_state = i_sts.last ? S_DONE : S_READ;
            S_DONE:  if (w_load_out) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

endmodule

/* design/pba_dp.sv */
// datapath of the page bitmap allocator: range unit, bitmap memory, counters
module pba_dp #(
    parameter int MAX_PAGES = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pba_pkg::t_ctl     i_ctl,
    input  pba_pkg::t_in_word i_in_word,
    output pba_pkg::t_sts     o_sts,
    output pba_pkg::t_out_word o_out_word
);

    localparam int WORDS = (MAX_PAGES + 63) / 64;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW    = $clog2(MAX_PAGES + 1);
    localparam logic [PW-1:0]  MAXP  = PW'(MAX_PAGES);
    localparam logic [20:0]    MAXC  = 21'(MAX_PAGES);
    localparam logic [WAW-1:0] LASTW = WAW'(WORDS - 1);

    // bitmap memory: upper half allocatable, lower half not-used
    logic [127:0] r_mem [WORDS];
    logic [127:0] r_rdata;

    logic [2:0]     r_cmd;
    logic [63:0]    r_base, r_len;
    logic [31:0]    r_faddr;
    logic [32:0]    r_end;
    logic           r_len0, r_basehi;
    logic [PW-1:0]  r_lo, r_hi;
    logic [WAW-1:0] r_wptr;
    logic [PW-1:0]  r_extent, r_total, r_free, r_resv;
    logic [1:0]     r_status;
    logic [31:0]    r_addr;
    pba_pkg::t_out_word r_out;

    // end of range, cut at 4 GiB
    logic [64:0] w_sum;
    logic        w_over;
    assign w_sum  = {1'b0, r_base} + {1'b0, r_len};
    assign w_over = (w_sum[64:33] != '0) || (w_sum[32] && (w_sum[31:0] != '0));

    // page bounds, inward and outward
    logic [32:0] w_sp, w_ep;
    logic [20:0] w_in_lo, w_in_l, w_out_lo, w_out_l, w_lo, w_hi, w_fp;
    logic        w_in_ok, w_out_ok;
    always_comb begin
        w_sp     = {1'b0, r_base[31:0]} + 33'd4095;
        w_in_lo  = w_sp[32:12];
        w_in_l   = (r_end[32:12] > MAXC) ? MAXC : r_end[32:12];
        w_in_ok  = !r_len0 && !r_basehi && (w_in_lo < w_in_l);
        w_ep     = r_end + 33'd4095;
        w_out_lo = {1'b0, r_base[31:12]};
        w_out_l  = r_end[32] ? 21'h100000 : w_ep[32:12];
        if (w_out_l > MAXC) w_out_l = MAXC;
        w_out_ok = !r_len0 && !r_basehi && (w_out_lo < w_out_l);
        w_lo     = (r_cmd == pba_pkg::CMD_RESERVE) ? w_out_lo : w_in_lo;
        w_hi     = (r_cmd == pba_pkg::CMD_RESERVE) ? w_out_l : w_in_l;
        w_fp     = {1'b0, r_faddr[31:12]};
    end

    // whether the item walks the bitmap
    logic w_walk;
    always_comb begin
        case (r_cmd) inside
            pba_pkg::CMD_USABLE:  w_walk = w_in_ok;
            pba_pkg::CMD_RESERVE: w_walk = w_out_ok;
            pba_pkg::CMD_FINAL:   w_walk = (r_extent != '0);
            pba_pkg::CMD_ALLOC:   w_walk = (r_total != '0);
            pba_pkg::CMD_FREE:    w_walk = (r_faddr[11:0] == 12'd0) && (w_fp < 21'(r_total));
            default:              w_walk = 1'b0;
        endcase
    end

    // word mask of the pages in range
    logic [PW-1:0]  w_hm1;
    logic [WAW-1:0] w_lo_w, w_last_w;
    logic [5:0]     w_lo_b, w_hi_b;
    logic [63:0]    w_mask;
    always_comb begin
        w_hm1    = r_hi - PW'(1);
        w_lo_w   = r_lo[WAW+5:6];
        w_last_w = w_hm1[WAW+5:6];
        w_lo_b   = (r_wptr == w_lo_w) ? r_lo[5:0] : 6'd0;
        w_hi_b   = (r_wptr == w_last_w) ? w_hm1[5:0] : 6'd63;
        w_mask   = ({64{1'b1}} << w_lo_b) & ({64{1'b1}} >> (6'd63 - w_hi_b));
    end

    // free pages of the word: count and lowest
    logic [63:0] w_fm;
    logic [6:0]  w_pc;
    logic [5:0]  w_first;
    logic        w_found;
    always_comb begin
        w_fm    = r_rdata[127:64] & r_rdata[63:0] & w_mask;
        w_pc    = '0;
        w_first = '0;
        for (int j = 0; j < 64; j++) w_pc = w_pc + 7'(w_fm[j]);
        for (int j = 63; j >= 0; j--) if (w_fm[j]) w_first = 6'(j);
        w_found = (w_fm != '0);
    end

    // modified word and its write enable
    logic [127:0] w_wdata;
    logic         w_we, w_free_ok;
    logic [63:0]  w_bit;
    always_comb begin
        w_bit     = 64'd1 << r_lo[5:0];
        w_free_ok = ((r_rdata[127:64] & ~r_rdata[63:0] & w_bit) != '0);
        w_wdata   = r_rdata;
        w_we      = 1'b0;
        case (r_cmd)
            pba_pkg::CMD_USABLE: begin
                w_wdata = r_rdata | {w_mask, w_mask};
                w_we    = 1'b1;
            end
            pba_pkg::CMD_RESERVE: begin
                w_wdata = r_rdata & ~{w_mask, w_mask};
                w_we    = 1'b1;
            end
            pba_pkg::CMD_ALLOC: begin
                w_wdata[63:0] = r_rdata[63:0] & ~(64'd1 << w_first);
                w_we          = w_found;
            end
            pba_pkg::CMD_FREE: begin
                w_wdata[63:0] = r_rdata[63:0] | w_bit;
                w_we          = w_free_ok;
            end
            default: w_we = 1'b0;
        endcase
    end

    // bitmap memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) r_mem[r_wptr] <= '0;
        else if (i_ctl.wr && w_we) r_mem[r_wptr] <= w_wdata;
        if (i_ctl.rd) r_rdata <= r_mem[r_wptr];
    end

    // status to the controller
    assign o_sts.walk     = w_walk;
    assign o_sts.last     = (r_wptr == w_last_w) || ((r_cmd == pba_pkg::CMD_ALLOC) && w_found);
    assign o_sts.clr_last = (r_wptr == LASTW);

    // control registers and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr   <= '0;
            r_extent <= '0;
            r_total  <= '0;
            r_free   <= '0;
            r_resv   <= '0;
        end else begin
            if (i_ctl.clr) r_wptr <= r_wptr + WAW'(1);
            if (i_ctl.calc2) begin
                r_wptr <= w_lo[WAW+5:6];
                case (r_cmd) inside
                    pba_pkg::CMD_USABLE, pba_pkg::CMD_EXTENT: begin
                        if (w_in_ok && (PW'(w_hi) > r_extent)) r_extent <= PW'(w_hi);
                    end
                    pba_pkg::CMD_FINAL: begin
                        r_total <= r_extent;
                        r_free  <= '0;
                        r_resv  <= r_extent;
                        r_wptr  <= '0;
                    end
                    pba_pkg::CMD_ALLOC: r_wptr <= '0;
                    pba_pkg::CMD_FREE:  r_wptr <= w_fp[WAW+5:6];
                    default:            r_wptr <= w_lo[WAW+5:6];
                endcase
            end
            if (i_ctl.wr) begin
                r_wptr <= r_wptr + WAW'(1);
                case (r_cmd)
                    pba_pkg::CMD_FINAL: begin
                        r_free <= r_free + PW'(w_pc);
                        r_resv <= r_resv - PW'(w_pc);
                    end
                    pba_pkg::CMD_ALLOC:
                        if (w_found && (r_free != '0)) r_free <= r_free - PW'(1);
                    pba_pkg::CMD_FREE:
                        if (w_free_ok && (r_free < MAXP)) r_free <= r_free + PW'(1);
                    default: r_free <= r_free;
                endcase
            end
        end
    end

    // payload registers of the item at work
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= i_in_word.cmd;
            r_base  <= i_in_word.range_base;
            r_len   <= i_in_word.range_length;
            r_faddr <= i_in_word.free_address;
        end
        if (i_ctl.calc1) begin
            r_end    <= w_over ? 33'h100000000 : w_sum[32:0];
            r_len0   <= (r_len == '0);
            r_basehi <= (r_base[63:32] != '0);
        end
        if (i_ctl.calc2) begin
            r_addr <= '0;
            case (r_cmd) inside
                pba_pkg::CMD_USABLE, pba_pkg::CMD_EXTENT: begin
                    r_lo     <= PW'(w_lo);
                    r_hi     <= PW'(w_hi);
                    r_status <= w_in_ok ? pba_pkg::ST_OK : pba_pkg::ST_REJECT;
                end
                pba_pkg::CMD_RESERVE: begin
                    r_lo     <= PW'(w_lo);
                    r_hi     <= PW'(w_hi);
                    r_status <= w_out_ok ? pba_pkg::ST_OK : pba_pkg::ST_REJECT;
                end
                pba_pkg::CMD_FINAL: begin
                    r_lo     <= '0;
                    r_hi     <= r_extent;
                    r_status <= pba_pkg::ST_OK;
                end
                pba_pkg::CMD_ALLOC: begin
                    r_lo     <= '0;
                    r_hi     <= r_total;
                    r_status <= pba_pkg::ST_OOM;
                end
                pba_pkg::CMD_FREE: begin
                    r_lo     <= PW'(w_fp);
                    r_hi     <= PW'(w_fp) + PW'(1);
                    r_status <= ((r_faddr[11:0] == 12'd0) && (w_fp < 21'(r_total))) ?
                                pba_pkg::ST_OK : pba_pkg::ST_REJECT;
                end
                default: begin
                    r_lo     <= '0;
                    r_hi     <= '0;
                    r_status <= pba_pkg::ST_REJECT;
                end
            endcase
        end
        if (i_ctl.wr) begin
            if ((r_cmd == pba_pkg::CMD_ALLOC) && w_found) begin
                r_status <= pba_pkg::ST_OK;
                r_addr   <= 32'({r_wptr, w_first}) << 12;
            end
            if ((r_cmd == pba_pkg::CMD_FREE) && !w_free_ok) r_status <= pba_pkg::ST_REJECT;
        end
        if (i_ctl.done) begin
            r_out.status <= ((r_cmd == pba_pkg::CMD_FINAL) &&
                             ((r_total == '0) || (r_free == '0))) ?
                            pba_pkg::ST_NOUSE : r_status;
            r_out.page_address   <= r_addr;
            r_out.total_count    <= 17'(r_total);
            r_out.free_count     <= 17'(r_free);
            r_out.reserved_count <= 17'(r_resv);
        end
    end

    assign o_out_word = r_out;

    // checks
    a_wptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.wr |-> (r_wptr <= LASTW))
        else $error("word pointer beyond bitmap");
    a_free_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= MAXP)
        else $error("free count beyond page limit");
    a_extent_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_extent <= MAXP) && (r_total <= MAXP))
        else $error("extent beyond page limit");
    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.wr && o_sts.last) |=> !i_ctl.rd)
        else $error("read after last word");

endmodule

/* design/page_bitmap_allocator_top.sv */
// top level of the page bitmap allocator
//
//  channel | direction | handshake                 | word
//  in      | input     | i_in_valid / o_in_ready   | i_in_word  (pba_pkg::t_in_word)
//  out     | output    | o_out_valid / i_out_ready | o_out_word (pba_pkg::t_out_word)
//
// an item does CALC1, CALC2, then READ and WRITE for each 64-page bitmap word it walks:
// range marking walks the words of the range, finalize the words below the extent,
// allocate the words up to the first free page, a free that passes its checks one word
// after reset, clearing all (MAX_PAGES+63)/64 words (1024 by default) holds ready low
// reset is synchronous, active low; the result register holds until taken,
// and a finished item waits in its last state while the result register is full
module page_bitmap_allocator_top #(
    parameter int MAX_PAGES = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pba_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pba_pkg::t_out_word  o_out_word
);

    pba_pkg::t_ctl w_ctl;
    pba_pkg::t_sts w_sts;

    // controller
    pba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    // datapath
    pba_dp #(
        .MAX_PAGES (MAX_PAGES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_in_word  (i_in_word),
        .o_sts      (w_sts),
        .o_out_word (o_out_word)
    );

endmodule
